// ----- rtl/core/srs_pkg.sv -----
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the octant-split radius search core.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int IN_COORD_W     = 24;
  localparam int TOL_W          = 23;
  localparam int RAD_W          = 23;
  localparam int IDX_W          = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    W_SUM,
    W_OCT,
    W_QRY
  } walk_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DIVP_GO,
    S_DIVP_WAIT,
    S_OCT,
    S_DIVO_GO,
    S_DIVO_WAIT,
    S_QSET,
    S_SCAN,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic       load;
    logic       build_start;
    logic       oct_clr;
    logic       walk_start;
    logic       walk_en;
    walk_mode_t mode;
    logic       div_start;
    logic       div_oct;
    logic [2:0] div_b;
    logic [1:0] div_a;
    logic       build_done;
    logic       qry_start;
    logic       qset;
    logic       final_req;
  } cmd_t;

  typedef struct packed {
    logic walk_idle;
    logic div_done;
    logic out_free;
    logic index_ready;
  } sts_t;

endpackage

// ----- rtl/core/srs_div.sv -----
// ----------------------------------------------------------------------------
// srs_div
// Radix-2 restoring divider, one quotient bit per cycle. Returns the floor of
// a signed numerator over a positive unsigned denominator.
// ----------------------------------------------------------------------------
module srs_div #(
  parameter int NW = 33,
  parameter int DW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CNTW-1:0] cnt_r;
  logic          neg_r;
  logic [NW-1:0] mag_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic          take;
  logic [NW-1:0] qadj;

  assign trial = {rem_r, mag_r[NW-1]};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NW-1];
      mag_r <= num[NW-1] ? NW'(-num) : NW'(num);
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= take ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      mag_r <= {mag_r[NW-2:0], take};
    end
  end

  // negative side: -ceil(|num|/den)
  assign qadj = mag_r + NW'(rem_r != '0);
  assign quo  = neg_r ? $signed(-qadj) : $signed(mag_r);
  assign done = done_r;

endmodule

// ----- rtl/core/srs_ctrl.sv -----
// ----------------------------------------------------------------------------
// srs_ctrl
// Sequencer: load, index build (sums, divisions, octant pass) and query scan.
// ----------------------------------------------------------------------------
module srs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          op,
  input  logic          last_point,
  input  srs_pkg::sts_t sts,
  output srs_pkg::cmd_t cmd
);

  srs_pkg::state_t state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [2:0] octb_r, octb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srs_pkg::S_IDLE;
      axis_r  <= '0;
      octb_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      octb_r  <= octb_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    octb_nxt  = octb_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.mode  = srs_pkg::W_SUM;
    cmd.div_a = axis_r;
    cmd.div_b = octb_r;
    case (state_r)
      srs_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (op == srs_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
            if (last_point) begin
              cmd.build_start = 1'b1;
              cmd.walk_start  = 1'b1;
              state_nxt       = srs_pkg::S_SUM;
            end
          end else begin
            cmd.qry_start = 1'b1;
            state_nxt = sts.index_ready ? srs_pkg::S_QSET : srs_pkg::S_FINAL;
          end
        end
      end
      srs_pkg::S_SUM: begin
        cmd.walk_en = 1'b1;
        if (sts.walk_idle) begin
          axis_nxt  = '0;
          state_nxt = srs_pkg::S_DIVP_GO;
        end
      end
      srs_pkg::S_DIVP_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = srs_pkg::S_DIVP_WAIT;
      end
      srs_pkg::S_DIVP_WAIT: begin
        if (sts.div_done) begin
          if (axis_r == 2'd2) begin
            axis_nxt       = '0;
            cmd.oct_clr    = 1'b1;
            cmd.walk_start = 1'b1;
            state_nxt      = srs_pkg::S_OCT;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = srs_pkg::S_DIVP_GO;
          end
        end
      end
      srs_pkg::S_OCT: begin
        cmd.walk_en = 1'b1;
        cmd.mode    = srs_pkg::W_OCT;
        if (sts.walk_idle) begin
          axis_nxt  = '0;
          octb_nxt  = '0;
          state_nxt = srs_pkg::S_DIVO_GO;
        end
      end
      srs_pkg::S_DIVO_GO: begin
        cmd.div_oct   = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = srs_pkg::S_DIVO_WAIT;
      end
      srs_pkg::S_DIVO_WAIT: begin
        cmd.div_oct = 1'b1;
        if (sts.div_done) begin
          if (axis_r == 2'd2) begin
            axis_nxt = '0;
            if (octb_r == 3'd7) begin
              cmd.build_done = 1'b1;
              state_nxt      = srs_pkg::S_IDLE;
            end else begin
              octb_nxt  = octb_r + 3'd1;
              state_nxt = srs_pkg::S_DIVO_GO;
            end
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = srs_pkg::S_DIVO_GO;
          end
        end
      end
      srs_pkg::S_QSET: begin
        cmd.qset       = 1'b1;
        cmd.walk_start = 1'b1;
        state_nxt      = srs_pkg::S_SCAN;
      end
      srs_pkg::S_SCAN: begin
        cmd.walk_en = 1'b1;
        cmd.mode    = srs_pkg::W_QRY;
        if (sts.walk_idle) state_nxt = srs_pkg::S_FINAL;
      end
      srs_pkg::S_FINAL: begin
        cmd.final_req = 1'b1;
        if (sts.out_free) state_nxt = srs_pkg::S_IDLE;
      end
      default: state_nxt = srs_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/srs_datapath.sv -----
// ----------------------------------------------------------------------------
// srs_datapath
// Point store, centroid accumulators, divider, split planes, query pipeline
// and result register.
// ----------------------------------------------------------------------------
module srs_datapath #(
  parameter int MAX_POINTS = srs_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = srs_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  srs_pkg::cmd_t                           cmd,
  output srs_pkg::sts_t                           sts,
  input  logic signed [srs_pkg::IN_COORD_W-1:0]   in_x,
  input  logic signed [srs_pkg::IN_COORD_W-1:0]   in_y,
  input  logic signed [srs_pkg::IN_COORD_W-1:0]   in_z,
  input  logic        [srs_pkg::RAD_W-1:0]        in_radius,
  input  logic                                    cfg_valid,
  input  logic        [srs_pkg::TOL_W-1:0]        cfg_data,
  input  logic                                    out_tready,
  output logic                                    out_valid,
  output logic        [srs_pkg::IDX_W-1:0]        out_idx,
  output logic                                    out_found,
  output logic                                    out_last
);

  localparam int C    = COORD_BITS;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int SW   = C + CW;
  localparam int NW   = SW + 2;
  localparam int DW   = CW + 1;
  localparam int TW   = srs_pkg::TOL_W;
  localparam int RW   = srs_pkg::RAD_W;
  localparam int XW   = srs_pkg::IDX_W;
  localparam int EW   = ((C > TW) ? C : TW) + 2;
  localparam int MW   = ((C + 1) > RW) ? (C + 1) : RW;
  localparam int SQW  = 2 * RW;
  localparam int SSW  = SQW + 2;

  // configuration and point count
  logic [TW-1:0] cfg_tol_r, tol_r;
  logic [CW-1:0] cnt_r, cnt_eff;
  logic          rdy_r;
  logic          wr_en;

  // point store
  logic [3*C-1:0] mem [MAX_POINTS];
  logic [3*C-1:0] rd_r;

  // walker pipeline
  logic [CW-1:0] ptr_r;
  logic          issue, adv, match;
  logic          v1_r, v2_r, v3_r, in2_r;
  logic [IW-1:0] idx1_r, idx2_r, idx3_r;
  logic [RW-1:0] d2_r [3];
  logic [SQW-1:0] sq3_r [3];
  logic [SQW-1:0] sq_nxt [3];
  logic [SSW-1:0] sqsum;

  // build state
  logic signed [SW-1:0] acc_r [3];
  logic signed [SW-1:0] osum_r [8][3];
  logic [CW-1:0]        ocnt_r [8];
  logic signed [C-1:0]  prim_r [3];
  logic signed [C-1:0]  oct_r [8][3];
  logic                 fin_r;

  // query state
  logic signed [C-1:0]  q_in [3];
  logic signed [C-1:0]  q_r [3];
  logic signed [C-1:0]  qoct_r [3];
  logic [RW-1:0]        r_r;
  logic [SQW-1:0]       r2_r;
  logic [SQW-1:0]       r2_nxt;
  logic [5:0]           bkt_r;

  // results
  logic          pend_v_r;
  logic [IW-1:0] pend_idx_r;
  logic          out_v_r, out_found_r, out_last_r;
  logic [XW-1:0] out_idx_r;
  logic          out_free;

  // stage 1 decode
  logic signed [C-1:0] p1 [3];
  logic [2:0]          b1;

  // stage 2 tests
  logic [RW-1:0] d2_nxt [3];
  logic          in2_nxt;

  // divider hookup
  logic signed [SW-1:0] num_sel;
  logic [CW-1:0]        n_sel;
  logic signed [NW-1:0] div_num;
  logic [DW-1:0]        div_den;
  logic                 div_empty, div_go, udone;
  logic signed [NW-1:0] quo;

  // query setup
  logic [2:0]          qo, qs;
  logic signed [C-1:0] qsel [3];

  assign q_in[0] = C'(in_x);
  assign q_in[1] = C'(in_y);
  assign q_in[2] = C'(in_z);

  assign cnt_eff = rdy_r ? '0 : cnt_r;
  assign wr_en   = cmd.load && (cnt_eff < CW'(MAX_POINTS));
  assign out_free = !out_v_r || out_tready;
  assign adv     = !(match && pend_v_r && !out_free);
  assign issue   = cmd.walk_en && adv && (ptr_r < cnt_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_eff[IW-1:0]] <= {q_in[2], q_in[1], q_in[0]};
    if (issue) rd_r <= mem[ptr_r[IW-1:0]];
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p1[a] = rd_r[a*C +: C];
      b1[a] = p1[a] > prim_r[a];
    end
  end

  // bucket bounds, box test and absolute deltas
  always_comb begin
    logic signed [EW-1:0] pe, tl, pp, po;
    logic signed [C:0]    dq;
    logic [C:0]           ad;
    logic [MW-1:0]        adm;
    in2_nxt = 1'b1;
    for (int a = 0; a < 3; a++) begin
      pe = EW'(p1[a]);
      tl = $signed({{(EW-TW){1'b0}}, tol_r});
      pp = EW'(prim_r[a]);
      po = EW'(qoct_r[a]);
      if (bkt_r[a]) begin
        if (pe + tl < pp) in2_nxt = 1'b0;
      end else begin
        if (pe > pp + tl) in2_nxt = 1'b0;
      end
      if (bkt_r[a+3]) begin
        if (pe + tl < po) in2_nxt = 1'b0;
      end else begin
        if (pe > po + tl) in2_nxt = 1'b0;
      end
      dq  = (C+1)'(p1[a]) - (C+1)'(q_r[a]);
      ad  = dq[C] ? (C+1)'(-dq) : (C+1)'(dq);
      adm = MW'(ad);
      if (adm >= MW'(r_r)) in2_nxt = 1'b0;
      d2_nxt[a] = RW'(adm);
    end
  end

  // full-width squares
  always_comb begin
    for (int a = 0; a < 3; a++) sq_nxt[a] = d2_r[a] * d2_r[a];
  end
  assign r2_nxt = r_r * r_r;

  assign sqsum = SSW'(sq3_r[0]) + SSW'(sq3_r[1]) + SSW'(sq3_r[2]);
  assign match = v3_r && (sqsum < SSW'(r2_r));

  // divider operands
  assign num_sel   = cmd.div_oct ? osum_r[cmd.div_b][cmd.div_a] : acc_r[cmd.div_a];
  assign n_sel     = cmd.div_oct ? ocnt_r[cmd.div_b] : cnt_r;
  assign div_num   = $signed({num_sel[SW-1], num_sel, 1'b0})
                   + $signed({{(NW-CW){1'b0}}, n_sel});
  assign div_den   = {n_sel, 1'b0};
  assign div_empty = (n_sel == '0);
  assign div_go    = cmd.div_start && !div_empty;

  srs_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (udone),
    .quo   (quo)
  );

  always_comb begin
    for (int a = 0; a < 3; a++) qo[a] = q_r[a] > prim_r[a];
    for (int a = 0; a < 3; a++) begin
      qsel[a] = oct_r[qo][a];
      qs[a]   = q_r[a] > qsel[a];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_tol_r <= '0;
      cnt_r     <= '0;
      rdy_r     <= 1'b0;
      ptr_r     <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      fin_r     <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_valid) cfg_tol_r <= cfg_data;
      if (cmd.load) begin
        rdy_r <= 1'b0;
        cnt_r <= wr_en ? cnt_eff + 1'b1 : cnt_eff;
      end else if (cmd.build_done) begin
        rdy_r <= 1'b1;
      end
      if (cmd.walk_start) ptr_r <= '0;
      else if (issue) ptr_r <= ptr_r + 1'b1;
      if (adv) begin
        v1_r <= issue;
        v2_r <= v1_r && (cmd.mode == srs_pkg::W_QRY);
        v3_r <= v2_r && in2_r;
      end
      fin_r <= cmd.div_start && div_empty;

      if (cmd.qry_start) begin
        pend_v_r <= 1'b0;
      end else if (cmd.final_req && out_free) begin
        pend_v_r <= 1'b0;
      end else if (adv && match) begin
        pend_v_r   <= 1'b1;
        pend_idx_r <= idx3_r;
      end

      if (adv && match && pend_v_r) begin
        out_v_r     <= 1'b1;
        out_idx_r   <= XW'(pend_idx_r);
        out_found_r <= 1'b1;
        out_last_r  <= 1'b0;
      end else if (cmd.final_req && out_free) begin
        out_v_r     <= 1'b1;
        out_idx_r   <= pend_v_r ? XW'(pend_idx_r) : '0;
        out_found_r <= pend_v_r;
        out_last_r  <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r <= ptr_r[IW-1:0];
      idx2_r <= idx1_r;
      idx3_r <= idx2_r;
      in2_r  <= in2_nxt;
      for (int a = 0; a < 3; a++) begin
        d2_r[a]  <= d2_nxt[a];
        sq3_r[a] <= sq_nxt[a];
      end
    end

    if (cmd.build_start) begin
      tol_r <= cfg_tol_r;
      for (int a = 0; a < 3; a++) acc_r[a] <= '0;
    end else if (v1_r && cmd.mode == srs_pkg::W_SUM) begin
      for (int a = 0; a < 3; a++) acc_r[a] <= acc_r[a] + SW'(p1[a]);
    end

    if (cmd.oct_clr) begin
      for (int b = 0; b < 8; b++) begin
        ocnt_r[b] <= '0;
        for (int a = 0; a < 3; a++) osum_r[b][a] <= '0;
      end
    end else if (v1_r && cmd.mode == srs_pkg::W_OCT) begin
      ocnt_r[b1] <= ocnt_r[b1] + 1'b1;
      for (int a = 0; a < 3; a++) osum_r[b1][a] <= osum_r[b1][a] + SW'(p1[a]);
    end

    // empty set takes the fallback plane right away
    if (cmd.div_start && div_empty) begin
      if (cmd.div_oct) oct_r[cmd.div_b][cmd.div_a] <= prim_r[cmd.div_a];
      else prim_r[cmd.div_a] <= '0;
    end else if (udone) begin
      if (cmd.div_oct) oct_r[cmd.div_b][cmd.div_a] <= C'(quo);
      else prim_r[cmd.div_a] <= C'(quo);
    end

    if (cmd.qry_start) begin
      for (int a = 0; a < 3; a++) q_r[a] <= q_in[a];
      r_r <= in_radius;
    end
    if (cmd.qset) begin
      bkt_r <= {qs, qo};
      for (int a = 0; a < 3; a++) qoct_r[a] <= qsel[a];
      r2_r <= r2_nxt;
    end
  end

  assign sts.walk_idle   = (ptr_r == cnt_r) && !v1_r && !v2_r && !v3_r;
  assign sts.div_done    = udone || fin_r;
  assign sts.out_free    = out_free;
  assign sts.index_ready = rdy_r;

  assign out_valid = out_v_r;
  assign out_idx   = out_idx_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/core/octant_split_radius_search_core.sv -----
// ----------------------------------------------------------------------------
// octant_split_radius_search_core
// Fixed-radius neighbor search over up to MAX_POINTS stored 3D points.
// ----------------------------------------------------------------------------
// The load marked last builds the index: one pass over the N stored points
// for the overall centroid, three divisions, a second pass for the octant
// centroids and 24 more divisions on the bit-serial divider. In a query the
// scan reads one stored point per cycle (it stalls while a new match waits
// on an output the consumer has not taken) from the point memory through
// the test pipeline, emitting matches in ascending index order, or a single
// found=0 result when nothing matches. Bucket membership is evaluated during
// the scan from the split planes and the margin latched at build time.
// The margin register may be written at any time; it takes effect at the
// next build.
// ----------------------------------------------------------------------------
module octant_split_radius_search_core #(
  parameter int MAX_POINTS = srs_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = srs_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // x[23:0], y[47:24], z[71:48], radius[94:72]
  input  logic        in_tuser,   // operation
  input  logic        in_tlast,   // last_point
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [22:0] cfg_data,   // max_tol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // point_index[5:0]
  output logic        out_tuser,  // found
  output logic        out_tlast   // last
);

  srs_pkg::cmd_t cmd;
  srs_pkg::sts_t sts;
  logic [srs_pkg::IDX_W-1:0] out_idx;

  assign cfg_ready = 1'b1;

  srs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .op         (in_tuser),
    .last_point (in_tlast),
    .sts        (sts),
    .cmd        (cmd)
  );

  srs_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_x       ($signed(in_tdata[23:0])),
    .in_y       ($signed(in_tdata[47:24])),
    .in_z       ($signed(in_tdata[71:48])),
    .in_radius  (in_tdata[94:72]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_idx    (out_idx),
    .out_found  (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, out_idx};

endmodule
